@@ rtl/trial_division_prime_test_unit_assert.svh @@
// Assertion macros shared by the prime test RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active low).
`define TDPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdpt assertion failed");

// Clocked check that also holds during reset.
`define TDPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tdpt assertion failed");

`else

`define TDPT_ASSERT(label, clk, rst_n, prop)
`define TDPT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/tdpt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the trial-division prime test unit.
// No dependencies.
package tdpt_pkg;

    // First odd divisor tried and the stride between divisors.
    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned DIVISOR_STEP  = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_DIV,
        ST_EVAL,
        ST_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;         // capture input number
        logic init_div;     // d = 3, start a division
        logic bump;         // d += 2, start a division
        logic step;         // one restoring-division step
        logic set_verdict;  // capture verdict value
        logic verdict;
        logic store;        // move verdict into output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic neg;
        logic le_one;       // value <= 1
        logic two;
        logic even;
        logic div_last;     // last division step this cycle
        logic bound_hit;    // d > v / d
        logic rem_zero;
    } t_stat;

endpackage

@@ rtl/tdpt_chan_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the prime test unit.
// No dependencies.
interface tdpt_in_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface tdpt_out_if;
    logic valid;
    logic ready;
    logic prime;

    modport source (output valid, output prime, input ready);
    modport sink   (input valid, input prime, output ready);
endinterface

@@ rtl/tdpt_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: operand, odd divisor, bit-serial restoring divider, verdict.
// Depends on tdpt_pkg and the assertion macro header.
`include "trial_division_prime_test_unit_assert.svh"

module tdpt_datapath #(
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdpt_pkg::t_cmd    i_cmd,
    input  logic [WIDTH-1:0]  i_number,
    output tdpt_pkg::t_stat   o_stat,
    output logic              o_prime
);

    localparam int N  = WIDTH - 1;      // magnitude bits of a non-negative value
    localparam int CW = $clog2(N);

    logic [WIDTH-1:0] r_v;
    logic [N-1:0]     r_d;
    logic [N-1:0]     r_rem;
    logic [N-1:0]     r_qr;             // dividend shifts out, quotient shifts in
    logic [CW-1:0]    r_cnt;
    logic             r_verdict;
    logic             r_prime;

    logic [N:0]       trial;
    logic [N:0]       diff;
    logic             ge;

    assign trial = {r_rem, r_qr[N-1]};
    assign diff  = trial - {1'b0, r_d};
    assign ge    = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= i_number;
        end
        if (i_cmd.init_div) begin
            r_d <= N'(tdpt_pkg::FIRST_DIVISOR);
        end else if (i_cmd.bump) begin
            r_d <= r_d + N'(tdpt_pkg::DIVISOR_STEP);
        end
        if (i_cmd.init_div || i_cmd.bump) begin
            r_rem <= '0;
            r_qr  <= r_v[N-1:0];
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_rem <= ge ? diff[N-1:0] : trial[N-1:0];
            r_qr  <= {r_qr[N-2:0], ge};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
        end
        if (i_cmd.store) begin
            r_prime <= r_verdict;
        end
    end

    always_comb begin
        o_stat.neg       = r_v[WIDTH-1];
        o_stat.le_one    = (r_v[N-1:0] <= N'(1));
        o_stat.two       = (r_v[N-1:0] == N'(2));
        o_stat.even      = ~r_v[0];
        o_stat.div_last  = (r_cnt == CW'(N - 1));
        o_stat.bound_hit = (r_d > r_qr);
        o_stat.rem_zero  = (r_rem == '0);
    end

    assign o_prime = r_prime;

    // divisor stays odd and at least three whenever it is in use
    `TDPT_ASSERT(a_odd_divisor, i_clk, i_rst_n, i_cmd.step |-> (r_d[0] && (r_d >= N'(3))))
    // a fresh division always starts from a zero remainder
    `TDPT_ASSERT(a_div_start, i_clk, i_rst_n, (i_cmd.init_div || i_cmd.bump) |=> (r_rem == '0 && r_cnt == '0))

endmodule

@@ rtl/tdpt_ctrl.sv @@
`timescale 1ns / 1ps
// Controller FSM: input/output handshake and sequencing of the divider.
// Depends on tdpt_pkg and the assertion macro header.
`include "trial_division_prime_test_unit_assert.svh"

module tdpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tdpt_pkg::t_stat  i_stat,
    output tdpt_pkg::t_cmd   o_cmd
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tdpt_pkg::ST_SCREEN;
                end
            end
            tdpt_pkg::ST_SCREEN: begin
                if (i_stat.neg || i_stat.le_one || i_stat.two || i_stat.even) begin
                    n_state = tdpt_pkg::ST_DONE;
                end else begin
                    n_state = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = tdpt_pkg::ST_EVAL;
                end
            end
            tdpt_pkg::ST_EVAL: begin
                if (i_stat.bound_hit || i_stat.rem_zero) begin
                    n_state = tdpt_pkg::ST_DONE;
                end else begin
                    n_state = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tdpt_pkg::ST_SCREEN: begin
                if (i_stat.neg || i_stat.le_one) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else if (i_stat.two) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b1;
                end else if (i_stat.even) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else begin
                    o_cmd.init_div = 1'b1;
                end
            end
            tdpt_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            tdpt_pkg::ST_EVAL: begin
                // bound is checked before divisibility, as in the loop test
                if (i_stat.bound_hit) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b1;
                end else if (i_stat.rem_zero) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                end else begin
                    o_cmd.bump = 1'b1;
                end
            end
            tdpt_pkg::ST_DONE: begin
                o_cmd.store = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.store) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a new result only appears out of the done state
    `TDPT_ASSERT(a_out_from_done, i_clk, i_rst_n, (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == tdpt_pkg::ST_DONE))
    // a pending result is never overwritten
    `TDPT_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.store |-> (!r_out_valid || i_out_ready))
    // an accepted beat is screened in the next cycle
    `TDPT_ASSERT(a_accept_screen, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == tdpt_pkg::ST_SCREEN))
    // evaluation only follows a finished division
    `TDPT_ASSERT(a_eval_after_div, i_clk, i_rst_n, (r_state == tdpt_pkg::ST_EVAL) |-> ($past(r_state) == tdpt_pkg::ST_DIV))

endmodule

@@ rtl/trial_division_prime_test_unit.sv @@
`timescale 1ns / 1ps
// Trial-division prime test: one input beat (number) in, one beat (prime) out.
// Channels: i_in is a valid/ready sink carrying number; o_out is a valid/ready
// source carrying prime. A beat moves when valid and ready are both high.
// The low WIDTH bits of number are a two's complement value. Negative values,
// 0, 1 and even values other than 2 are rejected in the screening state, and
// the result is stored from the done state. Odd values of 3 or more run a
// bit-serial restoring divider (WIDTH-1 steps, then an evaluate state, per
// divisor) over the odd divisors from 3 upward until one divides the value
// or the divisor exceeds the quotient. For WIDTH = 32 the worst case (a
// prime near 2^31) tries about 23,170 divisors. One item is in work at a
// time; i_in.ready is high only while idle, from the cycle after the result
// is stored. The result sits in an output register, so a new beat is taken
// while a finished result still waits. If the receiver stalls, the next
// result waits in the done state until the output register frees up;
// nothing is dropped. Reset (i_rst_n low, synchronous) returns the unit to
// idle and clears o_out.valid; the datapath registers are not reset.
// Depends on tdpt_pkg, tdpt_chan_if, tdpt_ctrl and tdpt_datapath.

module trial_division_prime_test_unit #(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdpt_in_if.sink   i_in,
    tdpt_out_if.source o_out
);

    tdpt_pkg::t_cmd  cmd;
    tdpt_pkg::t_stat stat;

    // sequencing: handshake and FSM
    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // operand, divisor, divider and output payload register
    tdpt_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_number (i_in.number),
        .o_stat   (stat),
        .o_prime  (o_out.prime)
    );

endmodule
